@@ rtl/rfr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rfr_pkg
// Shared types and constants of the radio fragment reassembler.
// ----------------------------------------------------------------------------
package rfr_pkg;

	localparam int MSG_BYTES     = 128;
	localparam int FRAG_BYTES    = 30;
	localparam int HDR_BYTES     = 2;
	localparam int CARRIED_BYTES = 32;
	localparam int READ_MAX      = 128;

	localparam int LANES     = 8;
	localparam int ROWS      = MSG_BYTES / LANES;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int OFF_W     = $clog2(MSG_BYTES + 1);
	localparam int CHUNKS    = CARRIED_BYTES / LANES;
	localparam int CHUNK_W   = $clog2(CHUNKS);
	localparam int PLEN_W    = $clog2(CARRIED_BYTES + 1);
	localparam int PAYLOAD_W = CARRIED_BYTES * 8;

	// register indexes
	localparam logic REG_LOCAL_ADDR = 1'b0;
	localparam logic REG_PEER_ADDR  = 1'b1;

	// actions
	localparam logic ACT_PACKET = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	// packet kinds
	localparam logic [1:0] KIND_CTRL  = 2'd0;
	localparam logic [1:0] KIND_FRAG  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_OTHER = 2'd3;

	// control opcodes
	localparam logic [1:0] OP_KA_REQ = 2'd0;
	localparam logic [1:0] OP_KA_RSP = 2'd1;

	// result status codes
	localparam logic [3:0] STS_TAKEN    = 4'd0;
	localparam logic [3:0] STS_COMPLETE = 4'd1;
	localparam logic [3:0] STS_BUSY     = 4'd2;
	localparam logic [3:0] STS_AHEAD    = 4'd3;
	localparam logic [3:0] STS_DUP      = 4'd4;
	localparam logic [3:0] STS_SHORT    = 4'd5;
	localparam logic [3:0] STS_CTRL     = 4'd6;
	localparam logic [3:0] STS_IGNORED  = 4'd7;
	localparam logic [3:0] STS_NODATA   = 4'd8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_WRITE,
		ST_READ,
		ST_DRAIN
	} state_t;

	// one write step into the store: eight payload bytes at most
	typedef struct packed {
		logic               en;
		logic [OFF_W-1:0]   offset;
		logic [CHUNK_W-1:0] chunk;
		logic [PLEN_W-1:0]  len;
	} wr_req_t;

endpackage

`default_nettype wire

@@ rtl/rfr_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rfr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/rfr_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rfr_store
// Message store as eight byte-lane RAMs; byte at offset o sits in lane o%8,
// row o/8. Writes spread up to eight payload bytes across the lanes per
// cycle; reads return one aligned 8-byte row.
// ----------------------------------------------------------------------------
module rfr_store (
	input  wire logic                            clk,
	input  wire rfr_pkg::wr_req_t                wr,
	input  wire logic [rfr_pkg::PAYLOAD_W-1:0]   payload,
	input  wire logic                            rd_en,
	input  wire logic [rfr_pkg::ROW_W-1:0]       rd_row,
	output logic      [rfr_pkg::LANES*8-1:0]     rd_data
);

	import rfr_pkg::*;

	localparam int LANE_W = $clog2(LANES);
	localparam int IDX_W  = CHUNK_W + LANE_W;

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [LANE_W-1:0] k;
		logic [IDX_W-1:0]  idx;
		logic [OFF_W-1:0]  off;
		logic              we;
		logic [7:0]        wbyte;

		// payload byte that lands in this lane during the current chunk
		assign k     = LANE_W'(l) - wr.offset[LANE_W-1:0];
		assign idx   = {wr.chunk, k};
		assign off   = wr.offset + OFF_W'(idx);
		assign we    = wr.en && (PLEN_W'(idx) < wr.len);
		assign wbyte = payload[{idx, 3'b000} +: 8];

		rfr_ram #(
			.WIDTH(8),
			.DEPTH(ROWS)
		) u_lane_ram (
			.clk  (clk),
			.we   (we),
			.waddr(off[LANE_W +: ROW_W]),
			.wdata(wbyte),
			.re   (rd_en),
			.raddr(rd_row),
			.rdata(rd_data[l*8 +: 8])
		);
	end

endmodule

`default_nettype wire

@@ rtl/radio_fragment_reassembler_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// radio_fragment_reassembler_core
// Receive path of a point-to-point radio link: reassembles numbered data
// fragments into a message store, answers keepalives, delivers messages.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; every request gives
// one or more results, each shown for a single cycle with valid high and the
// final one marked by last. Results cannot be held off. Control, ignored,
// busy and rejected packets, and reads with nothing to deliver, get their
// result from the decide state; an accepted data packet is written to the
// store in chunks of up to eight byte lanes per cycle; a read returns r
// 8-byte words (up to 16), one store row per cycle. The next request can
// be taken in the cycle the last result shows.
// ----------------------------------------------------------------------------
module radio_fragment_reassembler_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data,
	// request
	input  wire logic        start,
	output logic             busy,
	input  wire logic        action,
	input  wire logic [1:0]  packet_kind,
	input  wire logic [7:0]  seq_number,
	input  wire logic [5:0]  packet_len,
	input  wire logic [63:0] payload_word0,
	input  wire logic [63:0] payload_word1,
	input  wire logic [63:0] payload_word2,
	input  wire logic [63:0] payload_word3,
	input  wire logic [1:0]  ctrl_opcode,
	input  wire logic [63:0] source_address,
	input  wire logic [63:0] dest_address,
	input  wire logic [7:0]  read_count,
	// results
	output logic             valid,
	output logic [3:0]       status,
	output logic [7:0]       message_len,
	output logic [63:0]      data_word,
	output logic [3:0]       byte_count,
	output logic             last,
	output logic             send_keepalive_rsp,
	output logic             peer_alive
);

	import rfr_pkg::*;

	state_t state_q, state_d;

	// configuration registers
	logic [63:0] local_addr_q, peer_addr_q;

	// latched request
	logic                 action_q;
	logic [1:0]           kind_q;
	logic [7:0]           seq_q;
	logic [5:0]           plen_q;
	logic [PAYLOAD_W-1:0] payload_q;
	logic [1:0]           op_q;
	logic [63:0]          src_q, dst_q;
	logic [7:0]           rcount_q;

	// reassembly state
	logic [OFF_W-1:0]  wo_q, wo_d;
	logic [7:0]        exp_q, exp_d;
	logic [OFF_W-1:0]  ready_q, ready_d;
	logic [PLEN_W-1:0] n_q, n_d;
	logic [CHUNK_W-1:0] chunk_q;
	logic [OFF_W-1:0]  rd_len_q, rd_len_d;
	logic [ROW_W-1:0]  rd_row_q;
	logic              rd_vld_s1;
	logic [ROW_W-1:0]  rd_row_s1;

	// decision terms
	logic [OFF_W-1:0]  eff_wo;
	logic [7:0]        eff_exp;
	logic [5:0]        hdr_len;
	logic [PLEN_W-1:0] pay_len, wr_len;
	logic [OFF_W:0]    end_sum;
	logic [7:0]        min_cnt;
	logic [OFF_W-1:0]  rlen;
	logic              data_pkt, seq_ok, short_frag, go_write, go_read;
	logic              last_chunk;
	logic [OFF_W-1:0]  new_wo;
	logic [ROW_W-1:0]  last_row;
	logic [3:0]        rd_bc;
	logic [63:0]       rd_data, rd_word;

	wr_req_t wr;

	// result terms
	logic        emit;
	logic [3:0]  o_status;
	logic [7:0]  o_mlen;
	logic [63:0] o_word;
	logic [3:0]  o_bc;
	logic        o_last, o_rsp, o_alive;

	logic        valid_q;
	logic [3:0]  status_q;
	logic [7:0]  mlen_q;
	logic [63:0] word_q;
	logic [3:0]  bc_q;
	logic        last_q, rsp_q, alive_q;

	assign busy = (state_q != ST_IDLE);

	// ---------------------------------------------------------------- decide
	always_comb begin
		eff_wo  = (seq_q == 8'd0) ? '0 : wo_q;
		eff_exp = (seq_q == 8'd0) ? 8'd0 : exp_q;
		hdr_len = (plen_q < 6'(HDR_BYTES)) ? 6'd0 : plen_q - 6'(HDR_BYTES);
		pay_len = (hdr_len > 6'(CARRIED_BYTES)) ? PLEN_W'(CARRIED_BYTES)
			: PLEN_W'(hdr_len);
		end_sum = {1'b0, eff_wo} + (OFF_W + 1)'(pay_len);
		if (eff_wo >= OFF_W'(MSG_BYTES)) begin
			wr_len = '0;
		end else if (end_sum > (OFF_W + 1)'(MSG_BYTES)) begin
			wr_len = PLEN_W'(OFF_W'(MSG_BYTES) - eff_wo);
		end else begin
			wr_len = pay_len;
		end
		data_pkt   = (action_q == ACT_PACKET) && (kind_q == KIND_FRAG || kind_q == KIND_END)
			&& (ready_q == '0);
		seq_ok     = (seq_q == eff_exp);
		short_frag = (kind_q == KIND_FRAG) && (pay_len < PLEN_W'(FRAG_BYTES));
		go_write   = data_pkt && seq_ok && !short_frag;

		min_cnt = (8'(ready_q) < rcount_q) ? 8'(ready_q) : rcount_q;
		rlen    = (min_cnt > 8'(READ_MAX)) ? OFF_W'(READ_MAX) : OFF_W'(min_cnt);
		go_read = (action_q == ACT_READ) && (ready_q != '0) && (rlen != '0);
	end

	assign last_chunk = (PLEN_W'({chunk_q, 3'b000}) + PLEN_W'(8)) >= n_q;
	assign new_wo     = wo_q + OFF_W'(n_q);

	assign wr.en     = (state_q == ST_WRITE);
	assign wr.offset = wo_q;
	assign wr.chunk  = chunk_q;
	assign wr.len    = n_q;

	// read side: last row index and valid bytes of the row coming back
	assign last_row = ROW_W'((rd_len_q - OFF_W'(1)) >> 3);
	assign rd_bc    = (rd_row_s1 == last_row) ? 4'(((rd_len_q - OFF_W'(1)) & OFF_W'(7)) + 1)
		: 4'd8;

	always_comb begin
		for (int b = 0; b < LANES; b++) begin
			rd_word[b*8 +: 8] = (4'(b) < rd_bc) ? rd_data[b*8 +: 8] : 8'd0;
		end
	end

	rfr_store u_store (
		.clk    (clk),
		.wr     (wr),
		.payload(payload_q),
		.rd_en  (state_q == ST_READ),
		.rd_row (rd_row_q),
		.rd_data(rd_data)
	);

	// ------------------------------------------------------------ next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				priority if (go_write) begin
					state_d = ST_WRITE;
				end else if (go_read) begin
					state_d = ST_READ;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_WRITE: begin
				if (last_chunk) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				if (rd_row_q == last_row) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// --------------------------------------------------------------- outputs
	always_comb begin
		emit     = 1'b0;
		o_status = STS_TAKEN;
		o_mlen   = 8'd0;
		o_word   = 64'd0;
		o_bc     = 4'd0;
		o_last   = 1'b1;
		o_rsp    = 1'b0;
		o_alive  = 1'b0;
		wo_d     = wo_q;
		exp_d    = exp_q;
		ready_d  = ready_q;
		n_d      = n_q;
		rd_len_d = rd_len_q;
		unique case (state_q)
			ST_DECIDE: begin
				if (action_q == ACT_READ) begin
					if (ready_q == '0) begin
						emit     = 1'b1;
						o_status = STS_NODATA;
					end else begin
						ready_d  = '0;
						rd_len_d = rlen;
						if (rlen == '0) begin
							emit     = 1'b1;
							o_status = STS_COMPLETE;
						end
					end
				end else begin
					priority if (kind_q == KIND_CTRL) begin
						emit     = 1'b1;
						o_status = STS_CTRL;
						o_rsp    = (op_q == OP_KA_REQ) && (src_q == peer_addr_q)
							&& (dst_q == local_addr_q);
						o_alive  = (op_q == OP_KA_RSP);
					end else if (kind_q == KIND_OTHER) begin
						emit     = 1'b1;
						o_status = STS_IGNORED;
					end else if (ready_q != '0) begin
						emit     = 1'b1;
						o_status = STS_BUSY;
					end else begin
						// sequence zero restarts reassembly before the sequence and length checks
						wo_d    = eff_wo;
						exp_d   = eff_exp;
						n_d     = wr_len;
						o_alive = 1'b1;
						priority if (seq_q > eff_exp) begin
							emit     = 1'b1;
							o_status = STS_AHEAD;
						end else if (seq_q < eff_exp) begin
							emit     = 1'b1;
							o_status = STS_DUP;
						end else if (short_frag) begin
							emit     = 1'b1;
							o_status = STS_SHORT;
						end else begin
							emit = 1'b0;
						end
					end
				end
			end
			ST_WRITE: begin
				if (last_chunk) begin
					emit    = 1'b1;
					o_alive = 1'b1;
					if (kind_q == KIND_END) begin
						o_status = STS_COMPLETE;
						o_mlen   = 8'(new_wo);
						ready_d  = new_wo;
						wo_d     = '0;
						exp_d    = 8'd0;
					end else begin
						o_status = STS_TAKEN;
						wo_d     = new_wo;
						exp_d    = exp_q + 8'd1;
					end
				end
			end
			ST_IDLE, ST_READ, ST_DRAIN: begin
				if (rd_vld_s1) begin
					emit     = 1'b1;
					o_status = STS_COMPLETE;
					o_mlen   = 8'(rd_len_q);
					o_word   = rd_word;
					o_bc     = rd_bc;
					o_last   = (rd_row_s1 == last_row);
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			local_addr_q <= '0;
			peer_addr_q  <= '0;
			wo_q         <= '0;
			exp_q        <= '0;
			ready_q      <= '0;
			n_q          <= '0;
			chunk_q      <= '0;
			rd_len_q     <= '0;
			rd_row_q     <= '0;
			rd_vld_s1    <= 1'b0;
			rd_row_s1    <= '0;
			valid_q      <= 1'b0;
		end else begin
			state_q  <= state_d;
			wo_q     <= wo_d;
			exp_q    <= exp_d;
			ready_q  <= ready_d;
			n_q      <= n_d;
			rd_len_q <= rd_len_d;
			valid_q  <= emit;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_LOCAL_ADDR: local_addr_q <= cfg_data;
					REG_PEER_ADDR:  peer_addr_q  <= cfg_data;
					default:        local_addr_q <= local_addr_q;
				endcase
			end
			chunk_q   <= (state_q == ST_WRITE) ? chunk_q + CHUNK_W'(1) : '0;
			rd_row_q  <= (state_q == ST_READ) ? rd_row_q + ROW_W'(1) : '0;
			rd_vld_s1 <= (state_q == ST_READ);
			rd_row_s1 <= rd_row_q;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			action_q  <= action;
			kind_q    <= packet_kind;
			seq_q     <= seq_number;
			plen_q    <= packet_len;
			payload_q <= {payload_word3, payload_word2, payload_word1, payload_word0};
			op_q      <= ctrl_opcode;
			src_q     <= source_address;
			dst_q     <= dest_address;
			rcount_q  <= read_count;
		end
		status_q <= o_status;
		mlen_q   <= o_mlen;
		word_q   <= o_word;
		bc_q     <= o_bc;
		last_q   <= o_last;
		rsp_q    <= o_rsp;
		alive_q  <= o_alive;
	end

	assign valid              = valid_q;
	assign status             = status_q;
	assign message_len        = mlen_q;
	assign data_word          = word_q;
	assign byte_count         = bc_q;
	assign last               = last_q;
	assign send_keepalive_rsp = rsp_q;
	assign peer_alive         = alive_q;

endmodule

`default_nettype wire
